### rtl/hle_pkg.sv
// hle_pkg: constants, codes and shared types of the harmonic level extractor
// no dependencies; used by every other file of the block

package hle_pkg;

	localparam int BIN_AW        = 12;
	localparam int MAX_BINS      = 1 << BIN_AW;
	localparam int MAX_HARMONICS = 32;

	localparam int FUND_W  = 23;
	localparam int FREQ_W  = 28;
	localparam int FFT_W   = 14;
	localparam int SR_W    = 18;
	localparam int HC_W    = 6;
	localparam int MAG_W   = 24;
	localparam int BFRAC_W = 8;
	localparam int PROD_W  = FREQ_W + FFT_W;
	localparam int POS_IW  = PROD_W - BFRAC_W;
	localparam int ACC_W   = MAG_W + BFRAC_W;
	localparam int DB_W    = 17;
	localparam int LOG_FW  = 20;
	localparam int EXP_W   = 5;
	localparam int E_BIAS  = 24;
	localparam int LMAG_W  = 25;

	localparam int DB_K_W   = 35;
	localparam int K_LO_W   = 18;
	localparam int DPROD_W  = LMAG_W + K_LO_W;
	localparam int DSUM_W   = LMAG_W + DB_K_W + 1;
	localparam int DB_SHIFT = 44;

	localparam int CFG_IW = 2;
	localparam int CFG_DW = 18;

	localparam logic [FUND_W-1:0] F_LOW_Q8  = FUND_W'(5120);
	localparam logic [FUND_W-1:0] F_HIGH_Q8 = FUND_W'(5120000);

	localparam logic signed [DB_W-1:0] DB_FLOOR = -17'sd51200;
	localparam logic [DB_K_W-1:0]      DB_K     = 35'd25858279730;

	localparam logic [SR_W-1:0]  SR_RESET  = SR_W'(48000);
	localparam logic [FFT_W-1:0] FFT_RESET = FFT_W'(8192);
	localparam logic [HC_W-1:0]  HC_RESET  = HC_W'(16);

	typedef enum logic {
		OP_LOAD    = 1'b0,
		OP_ANALYZE = 1'b1
	} op_t;

	typedef enum logic [CFG_IW-1:0] {
		REG_SAMPLE_RATE    = 2'd0,
		REG_FFT_SIZE       = 2'd1,
		REG_HARMONIC_COUNT = 2'd2
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIVGO,
		ST_DIVWAIT,
		ST_RD_LO,
		ST_RD_HI,
		ST_INTERP,
		ST_LOGGO,
		ST_LOGWAIT,
		ST_EMIT
	} hle_state_t;

	typedef enum logic [2:0] {
		DB_IDLE,
		DB_NORM,
		DB_SQ,
		DB_ABS,
		DB_MLO,
		DB_MHI,
		DB_SUM
	} db_state_t;

	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] dividend;
		logic [SR_W-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic             start;
		logic [ACC_W-1:0] mag;
	} db_req_t;

	typedef struct packed {
		logic                   done;
		logic signed [DB_W-1:0] level;
	} db_rsp_t;

endpackage

### rtl/hle_if.sv
// hle_if: valid/ready channels of the harmonic level extractor
// item, result and register write channels; depends on hle_pkg

interface hle_in_if;
	import hle_pkg::*;
	logic              valid;
	logic              ready;
	logic              op;
	logic [BIN_AW-1:0] bin_addr;
	logic [MAG_W-1:0]  magnitude;
	logic [FUND_W-1:0] fundamental_in;

	modport source (output valid, op, bin_addr, magnitude, fundamental_in, input ready);
	modport sink (input valid, op, bin_addr, magnitude, fundamental_in, output ready);
endinterface

interface hle_out_if;
	import hle_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [HC_W-1:0]        harmonic_number;
	logic [FREQ_W-1:0]      harmonic_freq;
	logic signed [DB_W-1:0] level_db;
	logic                   last;

	modport source (output valid, harmonic_number, harmonic_freq, level_db, last, input ready);
	modport sink (input valid, harmonic_number, harmonic_freq, level_db, last, output ready);
endinterface

interface hle_cfg_if;
	import hle_pkg::*;
	logic              valid;
	logic              ready;
	logic [CFG_IW-1:0] index;
	logic [CFG_DW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/hle_div.sv
// hle_div: restoring divider, one quotient bit per cycle
// bin position = product / sample rate; depends on hle_pkg

module hle_div (
	input  logic             clk,
	input  logic             arst_n,
	input  hle_pkg::div_req_t req,
	output hle_pkg::div_rsp_t rsp
);
	import hle_pkg::*;

	localparam int CNT_W = $clog2(PROD_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SR_W-1:0]   rem_q;
	logic [SR_W-1:0]   den_q;
	logic [PROD_W-1:0] quo_q;

	logic [SR_W:0]     trial;
	logic [SR_W:0]     diff;
	logic              ge;
	logic              last_step;

	always_comb begin
		trial     = {rem_q, quo_q[PROD_W-1]};
		diff      = trial - {1'b0, den_q};
		ge        = trial >= {1'b0, den_q};
		last_step = cnt_q == CNT_W'(PROD_W - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last_step;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (last_step) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[SR_W-1:0] : trial[SR_W-1:0];
			quo_q <= {quo_q[PROD_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

### rtl/hle_db.sv
// hle_db: Q8.24 magnitude to level in 1/256 dB
// normalize, log2 by repeated squaring, scale by 20*log10(2); depends on hle_pkg

module hle_db (
	input  logic            clk,
	input  logic            arst_n,
	input  hle_pkg::db_req_t req,
	output hle_pkg::db_rsp_t rsp
);
	import hle_pkg::*;

	localparam int SQ_CNT_W = $clog2(LOG_FW);
	localparam int L_W      = LOG_FW + EXP_W + 1;
	localparam int KHI_W    = DB_K_W - K_LO_W;
	localparam logic [DSUM_W-1:0] DB_ROUND = DSUM_W'(1) << (DB_SHIFT - 1);

	db_state_t state_q, state_d;

	logic                   done_q;
	logic [ACC_W-1:0]       m_q;
	logic [EXP_W-1:0]       e_q;
	logic [LOG_FW-1:0]      frac_q;
	logic [SQ_CNT_W-1:0]    cnt_q;
	logic [LMAG_W-1:0]      lmag_q;
	logic                   neg_q;
	logic [DPROD_W-1:0]     prod_q;
	logic [DSUM_W-1:0]      acc_q;
	logic signed [DB_W-1:0] level_q;

	logic [2*ACC_W-1:0]     sq;
	logic [ACC_W:0]         sq_top;
	logic                   sq_carry;
	logic [ACC_W-1:0]       sq_next;
	logic [EXP_W:0]         ex;
	logic [L_W-1:0]         l_val;
	logic [L_W-1:0]         l_abs;
	logic [DSUM_W-1:0]      sum;
	logic [DB_W-1:0]        r;
	logic                   zero_start;

	always_comb begin
		sq         = m_q * m_q;
		sq_top     = sq[2*ACC_W-1:ACC_W-1];
		sq_carry   = sq_top[ACC_W];
		sq_next    = sq_carry ? sq_top[ACC_W:1] : sq_top[ACC_W-1:0];
		ex         = {1'b0, e_q} - (EXP_W+1)'(E_BIAS);
		l_val      = {ex, frac_q};
		l_abs      = l_val[L_W-1] ? (~l_val + 1'b1) : l_val;
		sum        = acc_q + {prod_q, {K_LO_W{1'b0}}};
		r          = sum[DSUM_W-1:DB_SHIFT];
		zero_start = req.start && (req.mag == '0);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			DB_IDLE: if (req.start && !zero_start) state_d = DB_NORM;
			DB_NORM: if (m_q[ACC_W-1]) state_d = DB_SQ;
			DB_SQ:   if (cnt_q == SQ_CNT_W'(LOG_FW - 1)) state_d = DB_ABS;
			DB_ABS:  state_d = DB_MLO;
			DB_MLO:  state_d = DB_MHI;
			DB_MHI:  state_d = DB_SUM;
			DB_SUM:  state_d = DB_IDLE;
			default: state_d = DB_IDLE;
		endcase
	end

	always_comb begin
		rsp.done  = done_q;
		rsp.level = level_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DB_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == DB_IDLE && zero_start) || state_q == DB_SUM;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			DB_IDLE: begin
				if (req.start) begin
					m_q   <= req.mag;
					e_q   <= EXP_W'(ACC_W - 1);
					cnt_q <= '0;
					if (zero_start) begin
						level_q <= DB_FLOOR;
					end
				end
			end
			DB_NORM: begin
				if (!m_q[ACC_W-1]) begin
					m_q <= {m_q[ACC_W-2:0], 1'b0};
					e_q <= e_q - 1'b1;
				end
			end
			DB_SQ: begin
				m_q    <= sq_next;
				frac_q <= {frac_q[LOG_FW-2:0], sq_carry};
				cnt_q  <= cnt_q + 1'b1;
			end
			DB_ABS: begin
				lmag_q <= l_abs[LMAG_W-1:0];
				neg_q  <= l_val[L_W-1];
			end
			DB_MLO: begin
				prod_q <= lmag_q * DB_K[K_LO_W-1:0];
			end
			DB_MHI: begin
				acc_q  <= DSUM_W'(prod_q) + DB_ROUND;
				prod_q <= DPROD_W'(lmag_q * DB_K[DB_K_W-1:K_LO_W]);
			end
			DB_SUM: begin
				level_q <= neg_q ? $signed(-r) : $signed(r);
			end
			default: begin
			end
		endcase
	end

endmodule

### rtl/harmonic_level_extractor_unit.sv
// harmonic_level_extractor_unit: spectrum store, held fundamental and harmonic level runs
// load transaction: written into the store on acceptance, one per cycle while idle
// analyze transaction: each harmonic passes through the 42-step serial
//   divider in hle_div and the normalize and 20-step squaring loop in hle_db
// no item is taken during a run; a finished result waits in the output register
// reset clears control and the fundamental, loads register defaults; store undefined until loaded

module harmonic_level_extractor_unit (
	input  logic      clk,
	input  logic      arst_n,
	hle_in_if.sink    items,
	hle_out_if.source results,
	hle_cfg_if.sink   cfg
);
	import hle_pkg::*;

	localparam logic [BFRAC_W:0] W_ONE = (BFRAC_W+1)'(1 << BFRAC_W);

	hle_state_t state_q, state_d;

	logic [SR_W-1:0]   sr_q;
	logic [FFT_W-1:0]  fft_q;
	logic [HC_W-1:0]   hc_q;
	logic [FUND_W-1:0] fund_q;

	logic [HC_W-1:0]   k_q;
	logic [HC_W-1:0]   count_q;
	logic [FREQ_W-1:0] hf_q;
	logic [PROD_W-1:0] prod_q;
	logic [BIN_AW-1:0] lo_q;
	logic [BIN_AW-1:0] hi_q;
	logic [BFRAC_W-1:0] bfrac_q;
	logic [ACC_W:0]    plo_q;
	logic [ACC_W-1:0]  a_q;

	logic [MAG_W-1:0]  store_mem [MAX_BINS];
	logic [MAG_W-1:0]  rd_data_q;

	logic                   out_valid_q;
	logic [HC_W-1:0]        out_num_q;
	logic [FREQ_W-1:0]      out_freq_q;
	logic signed [DB_W-1:0] out_db_q;
	logic                   out_last_q;

	div_req_t div_req;
	div_rsp_t div_rsp;
	db_req_t  db_req;
	db_rsp_t  db_rsp;

	logic              in_acc;
	logic              cfg_acc;
	logic              load_we;
	logic              analyze_acc;
	logic              in_band;
	logic [FUND_W-1:0] fund_next;
	logic [HC_W-1:0]   hc_sat;
	logic              run_ok;
	logic [POS_IW-1:0] q_lower;
	logic [BFRAC_W-1:0] q_frac;
	logic [POS_IW:0]   q_upper;
	logic              bin_zero;
	logic [BIN_AW-1:0] rd_addr;
	logic [BFRAC_W:0]  w_lo;
	logic [ACC_W:0]    interp_sum;
	logic              emit_go;
	logic              last_k;

	hle_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	hle_db u_db (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (db_req),
		.rsp    (db_rsp)
	);

	always_comb begin
		in_acc      = items.valid && items.ready;
		cfg_acc     = cfg.valid && cfg.ready;
		analyze_acc = in_acc && (op_t'(items.op) == OP_ANALYZE);
		in_band     = items.fundamental_in > F_LOW_Q8 && items.fundamental_in < F_HIGH_Q8;
		fund_next   = in_band ? items.fundamental_in : fund_q;
		hc_sat      = (hc_q > HC_W'(MAX_HARMONICS)) ? HC_W'(MAX_HARMONICS) : hc_q;
		run_ok      = fund_next != '0 && sr_q != '0 && hc_sat != '0;
		q_lower     = div_rsp.quotient[PROD_W-1:BFRAC_W];
		q_frac      = div_rsp.quotient[BFRAC_W-1:0];
		q_upper     = {1'b0, q_lower} + (POS_IW+1)'(q_frac != '0);
		bin_zero    = q_upper >= (POS_IW+1)'(fft_q >> 1) || q_upper >= (POS_IW+1)'(MAX_BINS);
		w_lo        = W_ONE - {1'b0, bfrac_q};
		interp_sum  = plo_q + (ACC_W+1)'(rd_data_q * bfrac_q);
		last_k      = k_q == count_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (analyze_acc && run_ok) state_d = ST_MUL;
			ST_MUL:     state_d = ST_DIVGO;
			ST_DIVGO:   state_d = ST_DIVWAIT;
			ST_DIVWAIT: if (div_rsp.done) state_d = bin_zero ? ST_LOGGO : ST_RD_LO;
			ST_RD_LO:   state_d = ST_RD_HI;
			ST_RD_HI:   state_d = ST_INTERP;
			ST_INTERP:  state_d = ST_LOGGO;
			ST_LOGGO:   state_d = ST_LOGWAIT;
			ST_LOGWAIT: if (db_rsp.done) state_d = ST_EMIT;
			ST_EMIT:    if (emit_go) state_d = last_k ? ST_IDLE : ST_MUL;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		items.ready      = state_q == ST_IDLE;
		cfg.ready        = 1'b1;
		load_we          = in_acc && (op_t'(items.op) == OP_LOAD);
		rd_addr          = (state_q == ST_RD_HI) ? hi_q : lo_q;
		div_req.start    = state_q == ST_DIVGO;
		div_req.dividend = prod_q;
		div_req.divisor  = sr_q;
		db_req.start     = state_q == ST_LOGGO;
		db_req.mag       = a_q;
		emit_go          = state_q == ST_EMIT && (!out_valid_q || results.ready);
	end

	assign results.valid           = out_valid_q;
	assign results.harmonic_number = out_num_q;
	assign results.harmonic_freq   = out_freq_q;
	assign results.level_db        = out_db_q;
	assign results.last            = out_last_q;

	// spectrum store
	always_ff @(posedge clk) begin
		if (load_we) begin
			store_mem[items.bin_addr] <= items.magnitude;
		end
		rd_data_q <= store_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sr_q        <= SR_RESET;
			fft_q       <= FFT_RESET;
			hc_q        <= HC_RESET;
			fund_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_acc) begin
				unique case (cfg_reg_t'(cfg.index))
					REG_SAMPLE_RATE:    sr_q  <= cfg.data[SR_W-1:0];
					REG_FFT_SIZE:       fft_q <= cfg.data[FFT_W-1:0];
					REG_HARMONIC_COUNT: hc_q  <= cfg.data[HC_W-1:0];
					default: begin
					end
				endcase
			end
			if (analyze_acc && in_band) begin
				fund_q <= items.fundamental_in;
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (analyze_acc) begin
					k_q     <= HC_W'(1);
					hf_q    <= FREQ_W'(fund_next);
					count_q <= hc_sat;
				end
			end
			ST_MUL: begin
				prod_q <= hf_q * fft_q;
			end
			ST_DIVWAIT: begin
				if (div_rsp.done) begin
					lo_q    <= q_lower[BIN_AW-1:0];
					hi_q    <= q_upper[BIN_AW-1:0];
					bfrac_q <= q_frac;
					if (bin_zero) begin
						a_q <= '0;
					end
				end
			end
			ST_RD_HI: begin
				plo_q <= rd_data_q * w_lo;
			end
			ST_INTERP: begin
				a_q <= interp_sum[ACC_W-1:0];
			end
			ST_EMIT: begin
				if (emit_go) begin
					out_num_q  <= k_q;
					out_freq_q <= hf_q;
					out_db_q   <= db_rsp.level;
					out_last_q <= last_k;
					k_q        <= k_q + 1'b1;
					hf_q       <= hf_q + FREQ_W'(fund_q);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### test/tb_top.sv
// tb_top: self-checking bench for harmonic_level_extractor_unit
// random load and analyze transactions with idling on both channels, checked per harmonic
// depends on hle_pkg, hle_if and the unit itself

module tb_top;
	import hle_pkg::*;

	localparam int CLK_HALF      = 10;
	localparam int RESET_CYCLES  = 6;
	localparam int MAX_WAIT      = 13;
	localparam int SETTLE_CYCLES = 300;
	localparam int HOLD_CYCLES   = 600;
	localparam int HOLD_AFTER    = 40;

	localparam logic [FUND_W-1:0]      FUND_MIN    = 23'd5120;
	localparam logic [FUND_W-1:0]      FUND_MAX    = 23'd5120000;
	localparam logic [FUND_W-1:0]      FUND_ALL    = 23'h7FFFFF;
	localparam logic [MAG_W-1:0]       MAG_FULL    = 24'hFFFFFF;
	localparam logic signed [DB_W-1:0] LEVEL_FLOOR = -17'sd51200;
	localparam logic [63:0]            DB_OCTAVE   = 64'd25858279730;
	localparam logic [CFG_IW-1:0]      REG_SPARE   = 2'd3;

	typedef struct {
		op_t               op;
		logic [BIN_AW-1:0] bin_addr;
		logic [MAG_W-1:0]  magnitude;
		logic [FUND_W-1:0] fundamental_in;
	} item_t;

	typedef struct {
		logic [HC_W-1:0]        harmonic_number;
		logic [FREQ_W-1:0]      harmonic_freq;
		logic signed [DB_W-1:0] level_db;
		logic                   last;
	} level_t;

	logic clk;
	logic arst_n;

	hle_in_if  items_ch();
	hle_out_if results_ch();
	hle_cfg_if cfg_ch();

	harmonic_level_extractor_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items_ch),
		.results(results_ch),
		.cfg(cfg_ch)
	);

	item_t  pending_items[$];
	level_t expected_levels[$];

	logic [MAG_W-1:0]  spectrum_copy [MAX_BINS];
	logic [FUND_W-1:0] held_fund;
	logic [SR_W-1:0]   sr_cfg;
	logic [FFT_W-1:0]  fft_cfg;
	logic [HC_W-1:0]   hc_cfg;

	item_t  tx_item;
	level_t rx_want;
	int     tx_wait, tx_run, rx_wait, rx_run;
	bit     tx_calm, rx_calm;
	int     hold_left;
	bit     hold_used;
	int     results_seen;
	int     bad_count, loads_done, analyses_done, settings_used;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("timeout: harmonic runs did not drain");
		$display("simulation failed");
		$finish;
	end

	// level in 1/256 dB of a Q8.24 magnitude
	function automatic logic signed [DB_W-1:0] level_of(input logic [63:0] a);
		int unsigned e;
		int          i;
		logic [63:0] t, m, frac_bits, mag, r;
		longint      l;
		bit          neg;
		if (a == 0)
			return LEVEL_FLOOR;
		e = 0;
		t = a;
		while (t > 1) begin
			t = t >> 1;
			e++;
		end
		m = (e <= 31) ? (a << (31 - e)) : (a >> (e - 31));
		frac_bits = '0;
		for (i = 0; i < LOG_FW; i++) begin
			m = (m * m) >> 31;
			frac_bits = frac_bits << 1;
			if (m >= (64'd1 << 32)) begin
				m = m >> 1;
				frac_bits = frac_bits | 64'd1;
			end
		end
		l = (longint'(e) - 24) * 64'sd1048576 + longint'(frac_bits);
		neg = l < 0;
		mag = neg ? 64'(-l) : 64'(l);
		r = (mag * DB_OCTAVE + (64'd1 << 43)) >> 44;
		return neg ? DB_W'(-r) : DB_W'(r);
	endfunction

	task automatic predict_levels(input item_t it);
		logic [63:0] hf, pos, lower, fr, upper, a;
		int          count, k;
		level_t      lv;
		if (it.op == OP_LOAD) begin
			spectrum_copy[it.bin_addr] = it.magnitude;
			loads_done++;
			return;
		end
		analyses_done++;
		if (it.fundamental_in > FUND_MIN && it.fundamental_in < FUND_MAX)
			held_fund = it.fundamental_in;
		if (held_fund == 0 || sr_cfg == 0)
			return;
		count = (hc_cfg > MAX_HARMONICS) ? MAX_HARMONICS : int'(hc_cfg);
		for (k = 1; k <= count; k++) begin
			hf = 64'(held_fund) * 64'(k);
			pos = hf * 64'(fft_cfg) / 64'(sr_cfg);
			lower = pos >> BFRAC_W;
			fr = pos & 64'd255;
			upper = lower + ((fr != 0) ? 64'd1 : 64'd0);
			if (upper >= 64'(fft_cfg >> 1) || upper >= 64'(MAX_BINS))
				a = '0;
			else
				a = 64'(spectrum_copy[lower[BIN_AW-1:0]]) * (64'd256 - fr)
					+ 64'(spectrum_copy[upper[BIN_AW-1:0]]) * fr;
			lv.harmonic_number = HC_W'(k);
			lv.harmonic_freq = hf[FREQ_W-1:0];
			lv.level_db = level_of(a);
			lv.last = (k == count);
			expected_levels.push_back(lv);
		end
	endtask

	function automatic logic [MAG_W-1:0] random_mag();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return MAG_FULL;
			2, 3: return MAG_W'($urandom_range(0, 255));
			default: return MAG_W'($urandom()) >> $urandom_range(0, MAG_W - 1);
		endcase
	endfunction

	function automatic item_t load_item(input int unsigned addr, input logic [MAG_W-1:0] mag);
		item_t it;
		it.op = OP_LOAD;
		it.bin_addr = BIN_AW'(addr);
		it.magnitude = mag;
		it.fundamental_in = FUND_W'($urandom());
		return it;
	endfunction

	function automatic item_t analyze_item(input logic [FUND_W-1:0] fin);
		item_t it;
		it.op = OP_ANALYZE;
		it.bin_addr = BIN_AW'($urandom());
		it.magnitude = MAG_W'($urandom());
		it.fundamental_in = fin;
		return it;
	endfunction

	// mostly in-band fundamentals, low ones keep the harmonics inside the spectrum
	function automatic item_t random_item(input int pct);
		if ($urandom_range(0, 99) >= pct)
			return load_item($urandom_range(0, MAX_BINS - 1), random_mag());
		case ($urandom_range(0, 7))
			0: return analyze_item(FUND_W'($urandom_range(0, FUND_MIN)));
			1: return analyze_item(FUND_W'($urandom_range(FUND_MAX, FUND_ALL)));
			2, 3, 4: return analyze_item(FUND_W'($urandom_range(FUND_MIN + 1, 256000)));
			default: return analyze_item(FUND_W'($urandom_range(FUND_MIN + 1, FUND_MAX - 1)));
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			REG_SAMPLE_RATE: sr_cfg = val[SR_W-1:0];
			REG_FFT_SIZE: fft_cfg = val[FFT_W-1:0];
			REG_HARMONIC_COUNT: hc_cfg = val[HC_W-1:0];
			default: ;
		endcase
	endtask

	task automatic wait_drain();
		do @(posedge clk);
		while (pending_items.size() != 0 || items_ch.valid || expected_levels.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input int n, input int pct);
		@(negedge clk);
		repeat (n) pending_items.push_back(random_item(pct));
		wait_drain();
		settings_used++;
	endtask

	task automatic report_field(input string field, input logic signed [63:0] want,
			input logic signed [63:0] got);
		bad_count++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
	endtask

	// sender
	always @(posedge clk) begin
		if (!arst_n) begin
			items_ch.valid <= 1'b0;
			tx_wait = 0;
		end else if (!items_ch.valid || items_ch.ready) begin
			if (items_ch.valid) begin
				predict_levels(tx_item);
				if (tx_run == 0) begin
					tx_run = $urandom_range(4, 40);
					tx_calm = ($urandom_range(0, 3) == 0);
				end
				tx_run--;
				tx_wait = tx_calm ? 0 : $urandom_range(0, MAX_WAIT);
			end
			if (tx_wait == 0 && pending_items.size() != 0) begin
				tx_item = pending_items.pop_front();
				items_ch.valid <= 1'b1;
				items_ch.op <= tx_item.op;
				items_ch.bin_addr <= tx_item.bin_addr;
				items_ch.magnitude <= tx_item.magnitude;
				items_ch.fundamental_in <= tx_item.fundamental_in;
			end else begin
				if (tx_wait != 0)
					tx_wait--;
				items_ch.valid <= 1'b0;
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		if (!arst_n) begin
			results_ch.ready <= 1'b0;
			results_seen <= 0;
			rx_wait = 0;
		end else begin
			if (results_ch.valid && results_ch.ready) begin
				results_seen <= results_seen + 1;
				if (expected_levels.size() == 0) begin
					bad_count++;
					$display("%0t: unexpected result, expected none, actual harmonic %0d level %0d",
						$time, results_ch.harmonic_number, results_ch.level_db);
				end else begin
					rx_want = expected_levels.pop_front();
					if (results_ch.harmonic_number !== rx_want.harmonic_number)
						report_field("harmonic_number", rx_want.harmonic_number,
							results_ch.harmonic_number);
					if (results_ch.harmonic_freq !== rx_want.harmonic_freq)
						report_field("harmonic_freq", rx_want.harmonic_freq,
							results_ch.harmonic_freq);
					if (results_ch.level_db !== rx_want.level_db)
						report_field("level_db", rx_want.level_db, results_ch.level_db);
					if (results_ch.last !== rx_want.last)
						report_field("last", rx_want.last, results_ch.last);
				end
				if (rx_run == 0) begin
					rx_run = $urandom_range(4, 40);
					rx_calm = ($urandom_range(0, 3) == 0);
				end
				rx_run--;
				rx_wait = rx_calm ? 0 : $urandom_range(0, MAX_WAIT);
			end
			if (hold_left != 0) begin
				results_ch.ready <= 1'b0;
			end else if (rx_wait != 0) begin
				rx_wait--;
				results_ch.ready <= 1'b0;
			end else begin
				results_ch.ready <= 1'b1;
			end
		end
	end

	// one long output stall so the unit backs up onto its input
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_used <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_used && results_seen >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end
	end

	initial begin
		int idx;
		items_ch.valid = 1'b0;
		items_ch.op = OP_LOAD;
		items_ch.bin_addr = '0;
		items_ch.magnitude = '0;
		items_ch.fundamental_in = '0;
		results_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_SAMPLE_RATE;
		cfg_ch.data = '0;
		arst_n = 1'b0;
		held_fund = '0;
		sr_cfg = 18'd48000;
		fft_cfg = 14'd8192;
		hc_cfg = 6'd16;
		bad_count = 0;
		loads_done = 0;
		analyses_done = 0;
		settings_used = 0;
		tx_run = 0;
		rx_run = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// fill every bin before anything reads the store
		@(negedge clk);
		for (idx = 0; idx < MAX_BINS; idx++)
			pending_items.push_back(load_item(idx, random_mag()));
		pending_items.push_back(analyze_item('0));
		pending_items.push_back(analyze_item(FUND_MIN));
		pending_items.push_back(analyze_item(FUND_MAX));
		pending_items.push_back(analyze_item(FUND_ALL));
		pending_items.push_back(load_item(0, '0));
		pending_items.push_back(load_item(MAX_BINS - 1, MAG_FULL));
		// 100 Hz lands between bins 17 and 18, its second harmonic between 34 and 35
		pending_items.push_back(load_item(17, '0));
		pending_items.push_back(load_item(18, '0));
		pending_items.push_back(load_item(34, MAG_FULL));
		pending_items.push_back(load_item(35, MAG_FULL));
		pending_items.push_back(analyze_item(23'd25600));
		pending_items.push_back(load_item(17, 24'd1));
		pending_items.push_back(analyze_item('0));
		pending_items.push_back(analyze_item(FUND_MIN + 1));
		pending_items.push_back(analyze_item(FUND_MAX - 1));
		pending_items.push_back(analyze_item(FUND_ALL));
		run_phase(60, 15);

		write_reg(REG_SAMPLE_RATE, 18'd192000);
		write_reg(REG_FFT_SIZE, 18'd16383);
		write_reg(REG_HARMONIC_COUNT, 18'd32);
		run_phase(40, 15);

		// every harmonic past the top bin
		write_reg(REG_SAMPLE_RATE, 18'd1);
		write_reg(REG_FFT_SIZE, 18'd2);
		write_reg(REG_HARMONIC_COUNT, 18'd63);
		run_phase(20, 20);

		write_reg(REG_SAMPLE_RATE, 18'd0);
		write_reg(REG_SPARE, 18'h3FFFF);
		run_phase(15, 30);

		write_reg(REG_SAMPLE_RATE, 18'd48000);
		write_reg(REG_FFT_SIZE, 18'd8192);
		write_reg(REG_HARMONIC_COUNT, 18'd0);
		run_phase(10, 30);

		// whole-bin positions
		write_reg(REG_SAMPLE_RATE, 18'd8192);
		write_reg(REG_HARMONIC_COUNT, 18'd1);
		@(negedge clk);
		pending_items.push_back(analyze_item(23'd12800));
		pending_items.push_back(analyze_item(23'd76800));
		run_phase(15, 20);

		repeat (3) begin
			case ($urandom_range(0, 2))
				0: write_reg(REG_SAMPLE_RATE, 18'd44100);
				1: write_reg(REG_SAMPLE_RATE, 18'd96000);
				default: write_reg(REG_SAMPLE_RATE, CFG_DW'($urandom_range(1, 192000)));
			endcase
			if ($urandom_range(0, 1) != 0)
				write_reg(REG_FFT_SIZE, CFG_DW'(1 << $urandom_range(1, 13)));
			else
				write_reg(REG_FFT_SIZE, CFG_DW'($urandom_range(2, 8192)));
			write_reg(REG_HARMONIC_COUNT, CFG_DW'($urandom_range(1, MAX_HARMONICS)));
			run_phase(30, 15);
		end

		write_reg(REG_SAMPLE_RATE, 18'd44100);
		write_reg(REG_FFT_SIZE, 18'd1024);
		write_reg(REG_HARMONIC_COUNT, 18'd33);
		run_phase(30, 15);

		$display("covered %0d bin loads and %0d analyze requests over %0d register settings",
			loads_done, analyses_done, settings_used);
		$display("checked %0d harmonic levels, %0d mismatches", results_seen, bad_count);
		if (bad_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
